FILE: rtl/core/huffman_code_bit_packer_assert.svh
// Assertion macros shared by the bit packer RTL.
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge of clk_i while reset is released.
`define HCBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising edge of clk_i, during reset too.
`define HCBP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define HCBP_ASSERT(label, prop, msg)
`define HCBP_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: rtl/core/hcbp_pkg.sv
// Package with the constants and types of the Huffman code bit packer.
`default_nettype none

package hcbp_pkg;

  // Default sizes of the symbol alphabet and of the longest code.
  localparam int unsigned ALPHABET_SIZE_DEF = 256;
  localparam int unsigned MAX_CODE_BITS_DEF = 32;

  // Bits in one packed output byte.
  localparam int unsigned BYTE_W = 8;

  // Operation carried by an input transaction.
  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_ENCODE = 1'b1
  } hcbp_func_e;

  // Control handed from the packing stage to the byte emitter.
  typedef struct packed {
    logic load;
    logic final_mark;
  } hcbp_emit_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/hcbp_if.sv
// Handshake interfaces for the symbol input and the packed byte output.
`default_nettype none

interface hcbp_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  symbol;
  logic [5:0]  code_length;
  logic [31:0] code_word;
  logic        end_of_stream;

  modport source (output valid, func, symbol, code_length, code_word, end_of_stream,
                  input ready);
  modport sink   (input valid, func, symbol, code_length, code_word, end_of_stream,
                  output ready);
endinterface

interface hcbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       stream_final;
  logic       run_last;

  modport source (output valid, packed_byte, stream_final, run_last, input ready);
  modport sink   (input valid, packed_byte, stream_final, run_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hcbp_ram.sv
// Generic single-port RAM with a registered read port.
`default_nettype none

module hcbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hcbp_emit.sv
// Byte emitter: holds one encode transaction's bytes, sends one per cycle while ready.
`default_nettype none
`include "huffman_code_bit_packer_assert.svh"

module hcbp_emit import hcbp_pkg::*; #(
  parameter int unsigned GRP_N = 5
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire hcbp_emit_ctl_t               ctl_i,
  input  wire logic [BYTE_W-1:0]            bytes_i [GRP_N],
  input  wire logic [$clog2(GRP_N)-1:0]     last_i,
  output logic                              free_o,
  hcbp_out_if.source                        out_o
);

  localparam int unsigned IW = $clog2(GRP_N);

  logic [BYTE_W-1:0] byte_q [GRP_N];
  logic [IW-1:0]     idx_q, idx_d;
  logic [IW-1:0]     last_q;
  logic              fin_q;
  logic              valid_q, valid_d;
  logic              pop, done;

  assign pop    = valid_q && out_o.ready;
  assign done   = pop && (idx_q == last_q);
  assign free_o = !valid_q || done;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (ctl_i.load) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (done) begin
      valid_d = 1'b0;
    end else if (pop) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      byte_q <= bytes_i;
      last_q <= last_i;
      fin_q  <= ctl_i.final_mark;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.packed_byte  = byte_q[idx_q];
  assign out_o.run_last     = (idx_q == last_q);
  assign out_o.stream_final = fin_q && (idx_q == last_q);

  // A new group may only arrive when the current one is finished.
  `HCBP_ASSERT(a_load_when_free, ctl_i.load |-> free_o, "emitter loaded while busy")
  // The read index never passes the last byte of the group.
  `HCBP_ASSERT(a_idx_bound, valid_q |-> (idx_q <= last_q), "emitter index out of range")
  // Taking the last byte without a new group empties the emitter.
  `HCBP_ASSERT(a_done_empties, (done && !ctl_i.load) |=> !valid_q,
               "emitter did not empty after last byte")

endmodule

`default_nettype wire

FILE: rtl/core/huffman_code_bit_packer.sv
// Top level of the Huffman code bit packer: code table RAM, packing stage and byte emitter.
`default_nettype none
`include "huffman_code_bit_packer_assert.svh"

// Huffman encoder back end. A load transaction (func = 0) writes the code length, clamped
// to MAX_CODE_BITS, and the right-aligned code word of one symbol into a single-port
// table RAM of ALPHABET_SIZE entries; an encode transaction (func = 1) reads the entry
// and appends the code MSB first to an 8-bit accumulator, and every byte that fills up is
// sent out with the earliest bit in bit 7. The encode transaction flagged end_of_stream
// also sends a partly filled byte, zero padded and marked stream_final, and clears the
// accumulator. Symbols at or above ALPHABET_SIZE are ignored by loads and add no bits.
// Table entries come up undefined after reset and must be loaded before they are used;
// there is no clearing pass. The input takes one transaction per cycle unless the input
// stage stalls: the table read happens at the accepting edge and the packing stage
// consumes the registered RAM data, so a load may be followed directly by an encode of
// the same symbol. The emitter registers the bytes of a transaction and sends them one
// per cycle while the receiver is ready; an encode that yields n bytes (up to five for
// 32-bit codes) keeps it busy until the last one leaves, and a later one that yields
// bytes waits, holding off the input; those of at most one byte stream at full rate.
module huffman_code_bit_packer import hcbp_pkg::*; #(
  parameter int unsigned ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int unsigned MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hcbp_in_if.sink    in_i,
  hcbp_out_if.source out_o
);

  // Table address, stored length and entry widths.
  localparam int unsigned AW    = $clog2(ALPHABET_SIZE);
  localparam int unsigned LW    = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned RW    = LW + MAX_CODE_BITS;
  // Most bytes one encode can yield: all full bytes of leftover plus code, and a pad byte.
  localparam int unsigned GRP_N = (MAX_CODE_BITS + BYTE_W - 1) / BYTE_W + 1;
  localparam int unsigned IW    = $clog2(GRP_N);
  localparam int unsigned CW    = $clog2(GRP_N + 1);
  // The packing window spans all bytes of a group; TW holds a bit count within it.
  localparam int unsigned WIN_W = GRP_N * BYTE_W;
  localparam int unsigned TW    = $clog2(WIN_W + 1);
  localparam int unsigned BW    = $clog2(BYTE_W);

  // ---------------------------------------------------------------------------------
  // Input acceptance and table access. The table is written by loads and read by
  // encodes at the edge that accepts the transaction.
  // ---------------------------------------------------------------------------------
  logic          accept;
  logic          in_alpha;
  logic [LW-1:0] len_clamped;
  logic [RW-1:0] ram_rdata;

  logic          s1_valid_q, s1_valid_d;
  logic          s1_func_q;
  logic          s1_eos_q;
  logic          s1_alpha_q;
  logic          s1_adv;

  assign accept   = in_i.valid && in_i.ready;
  assign in_alpha = {1'b0, in_i.symbol} < 9'(ALPHABET_SIZE);

  // Lengths above the longest supported code are stored as the longest code.
  assign len_clamped = (in_i.code_length > 6'(MAX_CODE_BITS)) ? LW'(MAX_CODE_BITS)
                                                              : LW'(in_i.code_length);

  hcbp_ram #(
    .WIDTH (RW),
    .DEPTH (ALPHABET_SIZE)
  ) u_table (
    .clk_i   (clk_i),
    .en_i    (accept),
    .we_i    (accept && (in_i.func == FUNC_LOAD) && in_alpha),
    .addr_i  (in_i.symbol[AW-1:0]),
    .wdata_i ({len_clamped, in_i.code_word[MAX_CODE_BITS-1:0]}),
    .rdata_o (ram_rdata)
  );

  // The input stage holds the control of the transaction whose table entry is being read.
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q  <= in_i.func;
      s1_eos_q   <= in_i.end_of_stream;
      s1_alpha_q <= in_alpha;
    end
  end

  // ---------------------------------------------------------------------------------
  // Packing stage. The leftover bits of the accumulator sit at the top of a window and
  // the masked code is shifted in directly below them; the window then splits into full
  // bytes, a partial byte (the new accumulator unless the stream ends), and nothing else.
  // ---------------------------------------------------------------------------------
  logic [BYTE_W-1:0]        partial_q, partial_d;
  logic [BW-1:0]            fill_q, fill_d;

  logic                     enc;
  logic [LW-1:0]            len;
  logic [MAX_CODE_BITS-1:0] code;
  logic [MAX_CODE_BITS-1:0] code_masked;
  logic [TW-1:0]            total;
  logic [TW-1:0]            shamt;
  logic [WIN_W-1:0]         win;
  logic [BYTE_W-1:0]        win_bytes [GRP_N];
  logic [TW-BW-1:0]         nfull;
  logic [BW-1:0]            rem;
  logic                     pad;
  logic [CW-1:0]            cnt;
  logic [BYTE_W-1:0]        new_partial;
  logic                     emit_free;
  hcbp_emit_ctl_t           emit_ctl;

  assign enc  = s1_valid_q && (s1_func_q == FUNC_ENCODE);
  assign len  = s1_alpha_q ? ram_rdata[RW-1 -: LW] : '0;
  assign code = s1_alpha_q ? ram_rdata[MAX_CODE_BITS-1:0] : '0;

  // Only the low len bits of the stored word belong to the code.
  assign code_masked = code & ~({MAX_CODE_BITS{1'b1}} << len);

  assign total = TW'(fill_q) + TW'(len);
  assign shamt = TW'(WIN_W) - total;
  assign win   = {partial_q, {(WIN_W - BYTE_W){1'b0}}} | (WIN_W'(code_masked) << shamt);

  always_comb begin
    for (int k = 0; k < GRP_N; k++) begin
      win_bytes[k] = win[WIN_W - 1 - k * BYTE_W -: BYTE_W];
    end
  end

  assign nfull = total[TW-1:BW];
  assign rem   = total[BW-1:0];

  always_comb begin
    new_partial = '0;
    for (int k = 0; k < GRP_N; k++) begin
      if (nfull == (TW-BW)'(k)) begin
        new_partial = win_bytes[k];
      end
    end
  end

  // The end of a stream sends any leftover bits as a zero-padded byte.
  assign pad = s1_eos_q && (rem != '0);
  assign cnt = CW'(nfull) + CW'(pad);

  // Loads and encodes that yield no byte never wait for the emitter.
  assign s1_adv = s1_valid_q && (!enc || (cnt == '0) || emit_free);

  assign emit_ctl.load       = s1_adv && enc && (cnt != '0);
  assign emit_ctl.final_mark = s1_eos_q;

  always_comb begin
    partial_d = partial_q;
    fill_d    = fill_q;
    if (s1_adv && enc) begin
      if (s1_eos_q) begin
        partial_d = '0;
        fill_d    = '0;
      end else begin
        partial_d = new_partial;
        fill_d    = rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      fill_q    <= '0;
    end else begin
      partial_q <= partial_d;
      fill_q    <= fill_d;
    end
  end

  // ---------------------------------------------------------------------------------
  // Output: the emitter takes a whole group and sends it one byte per cycle while the
  // receiver is ready. It takes the next group in the cycle its last byte leaves.
  // ---------------------------------------------------------------------------------
  hcbp_emit #(
    .GRP_N (GRP_N)
  ) u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (emit_ctl),
    .bytes_i (win_bytes),
    .last_i  (IW'(cnt - 1'b1)),
    .free_o  (emit_free),
    .out_o   (out_o)
  );

  // Accumulator bits not yet filled are always zero, so padding needs no masking.
  `HCBP_ASSERT_ALWAYS(a_partial_clean, (partial_q & (8'hFF >> fill_q)) == '0,
                      "accumulator holds bits below the fill level")
  // An encode flagged end of stream leaves the accumulator empty.
  `HCBP_ASSERT(a_eos_clears, (s1_adv && enc && s1_eos_q) |=> (fill_q == '0),
               "accumulator not cleared at end of stream")
  // A transaction held in the input stage keeps its place until it advances.
  `HCBP_ASSERT(a_stage_hold, (s1_valid_q && !s1_adv) |=> s1_valid_q,
               "stalled transaction dropped")

endmodule

`default_nettype wire

FILE: sim/huffman_code_bit_packer_tb.sv
// Self-checking testbench for the Huffman code bit packer: random and directed traffic.
`timescale 1ns / 100ps

module huffman_code_bit_packer_tb;
  import hcbp_pkg::*;

  // Cycles without progress on either port before the run is declared hung.
  // The slowest correct stretch is the long receiver hold-off, so this limit leaves a
  // wide margin.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Length of the deliberate receiver hold-off that backs the block up.
  localparam int unsigned HOLD_CYCLES    = 80;
  // Cycles to keep watching after the last expected byte.
  localparam int unsigned DRAIN_CYCLES   = 12;
  // Random transactions per idling phase.
  localparam int unsigned PHASE_ITEMS    = 60;

  // One input transaction as the block sees it.
  typedef struct packed {
    hcbp_func_e        func;
    logic [7:0]        symbol;
    logic [5:0]        code_length;
    logic [31:0]       code_word;
    logic              end_of_stream;
  } symbol_txn_t;

  // One output transaction: a packed byte and its two marks.
  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              stream_final;
    logic              run_last;
  } byte_txn_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  hcbp_in_if  sym_if ();
  hcbp_out_if byte_if ();

  huffman_code_bit_packer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sym_if),
    .out_o  (byte_if)
  );

  // Symbols waiting to be offered, and bytes the packer is expected to send.
  symbol_txn_t pending_syms[$];
  byte_txn_t   expected_bytes[$];

  // Our own copy of the code table and of the packing accumulator.
  logic [5:0]        code_len_tab  [256];
  logic [31:0]       code_word_tab [256];
  logic [BYTE_W-1:0] acc_byte = '0;
  int unsigned       acc_bits = 0;

  // Which symbols the stimulus has already loaded, so that no encode ever reads an
  // entry that was never written.
  bit          sym_loaded [256];
  logic [7:0]  loaded_syms[$];

  symbol_txn_t offered_sym;
  int unsigned n_queued      = 0;
  int unsigned n_accepted    = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles   = 0;
  int unsigned hold_cnt      = 0;
  logic        hold_trig     = 1'b0;

  // Idle percentages of both sides, changed between phases by the stimulus.
  int unsigned tx_idle_pct = 31;
  int unsigned rx_idle_pct = 80;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Prints one line per mismatch; the printing is capped so a dead block cannot
  // flood the log, but every mismatch is still counted.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 200) begin
      $display("%0t ns: mismatch: %s", $realtime, what);
    end
  endtask

  // Predicts the bytes one accepted transaction causes. A load only writes the
  // table (its length clamped to the longest code); an encode shifts the code into
  // the accumulator MSB first and emits every byte that fills. On end of stream a
  // partial byte goes out zero padded with the final mark; with an empty
  // accumulator the mark moves onto the last full byte, if there is one.
  task automatic pack_symbol(input symbol_txn_t txn);
    byte_txn_t   burst[$];
    logic [5:0]  len;
    logic [31:0] word;
    if (txn.func == FUNC_LOAD) begin
      code_len_tab[txn.symbol]  = (txn.code_length > MAX_CODE_BITS_DEF) ?
                                  6'(MAX_CODE_BITS_DEF) : txn.code_length;
      code_word_tab[txn.symbol] = txn.code_word;
      return;
    end
    len  = code_len_tab[txn.symbol];
    word = code_word_tab[txn.symbol];
    for (int i = int'(len) - 1; i >= 0; i--) begin
      acc_byte[BYTE_W - 1 - acc_bits] = word[i];
      acc_bits++;
      if (acc_bits == BYTE_W) begin
        burst.push_back('{packed_byte: acc_byte, stream_final: 1'b0, run_last: 1'b0});
        acc_byte = '0;
        acc_bits = 0;
      end
    end
    if (txn.end_of_stream) begin
      if (acc_bits != 0) begin
        burst.push_back('{packed_byte: acc_byte, stream_final: 1'b1, run_last: 1'b0});
      end else if (burst.size() != 0) begin
        burst[burst.size() - 1].stream_final = 1'b1;
      end
      acc_byte = '0;
      acc_bits = 0;
    end
    if (burst.size() != 0) begin
      burst[burst.size() - 1].run_last = 1'b1;
    end
    foreach (burst[k]) expected_bytes.push_back(burst[k]);
  endtask

  // Compares one received byte with the oldest expectation, field by field.
  task automatic check_byte(input byte_txn_t got);
    byte_txn_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %h", got.packed_byte));
      return;
    end
    want = expected_bytes.pop_front();
    if (got.packed_byte !== want.packed_byte) begin
      report_mismatch($sformatf("packed_byte got %h want %h",
                                got.packed_byte, want.packed_byte));
    end
    if (got.stream_final !== want.stream_final) begin
      report_mismatch($sformatf("stream_final got %b want %b on byte %h",
                                got.stream_final, want.stream_final, want.packed_byte));
    end
    if (got.run_last !== want.run_last) begin
      report_mismatch($sformatf("run_last got %b want %b on byte %h",
                                got.run_last, want.run_last, want.packed_byte));
    end
  endtask

  // Queues a table load and records the symbol as usable for encodes.
  task automatic queue_load(input logic [7:0] sym, input logic [5:0] len,
                            input logic [31:0] word, input logic eos);
    pending_syms.push_back('{func: FUNC_LOAD, symbol: sym, code_length: len,
                             code_word: word, end_of_stream: eos});
    n_queued++;
    if (!sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  // Queues an encode; the length and word fields carry noise the block must ignore.
  task automatic queue_encode(input logic [7:0] sym, input logic eos);
    pending_syms.push_back('{func: FUNC_ENCODE, symbol: sym,
                             code_length: 6'($urandom), code_word: $urandom,
                             end_of_stream: eos});
    n_queued++;
  endtask

  // Random traffic: mostly streams of encodes over loaded symbols, each closed by an
  // end-of-stream mark now and then, with table reloads mixed in. Lengths favor short
  // codes but reach zero, the full 32 bits and the clamped range above it.
  task automatic queue_random_items(input int unsigned count);
    logic [5:0] len;
    int unsigned pick;
    repeat (count) begin
      if ($urandom_range(0, 99) < 15) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          len = 6'($urandom_range(1, 12));
        end else if (pick < 90) begin
          len = 6'($urandom_range(13, 32));
        end else begin
          len = 6'($urandom_range(0, 63));
        end
        queue_load(8'($urandom), len, $urandom, 1'($urandom));
      end else begin
        queue_encode(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                     $urandom_range(0, 5) == 0);
      end
    end
  endtask

  // Waits until every queued transaction went in and every expected byte came out.
  task automatic wait_drained();
    while (n_accepted != n_queued || expected_bytes.size() != 0) @(negedge clk_i);
  endtask

  // Input driver: offers the next pending symbol whenever the port is free, with
  // random gaps. The predictor runs at the edge that accepts a transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_if.valid         <= 1'b0;
      sym_if.func          <= FUNC_LOAD;
      sym_if.symbol        <= '0;
      sym_if.code_length   <= '0;
      sym_if.code_word     <= '0;
      sym_if.end_of_stream <= 1'b0;
    end else begin
      if (sym_if.valid && sym_if.ready) begin
        pack_symbol(offered_sym);
        n_accepted <= n_accepted + 1;
      end
      if (!sym_if.valid || sym_if.ready) begin
        if (pending_syms.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          offered_sym           = pending_syms.pop_front();
          sym_if.valid         <= 1'b1;
          sym_if.func          <= offered_sym.func;
          sym_if.symbol        <= offered_sym.symbol;
          sym_if.code_length   <= offered_sym.code_length;
          sym_if.code_word     <= offered_sym.code_word;
          sym_if.end_of_stream <= offered_sym.end_of_stream;
        end else begin
          sym_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver hold-off counter: a one-cycle trigger from the stimulus starts a long
  // stretch with ready low, so the emitter backs up and stalls the input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
    end else if (hold_trig) begin
      hold_cnt <= HOLD_CYCLES;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Output monitor: checks every accepted byte and draws ready at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_if.ready <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        check_byte('{packed_byte: byte_if.packed_byte, stream_final: byte_if.stream_final,
                     run_last: byte_if.run_last});
      end
      byte_if.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Watchdog: a lost byte, a wedged handshake or an endless run of stray bytes shows
  // up as a long stretch with no input transaction and no expected output byte.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((sym_if.valid && sym_if.ready) ||
          (byte_if.valid && byte_if.ready && expected_bytes.size() != 0)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, under the first idling mix (sender 31, receiver 80 percent).
    // Table loads: shortest code, a full 32-bit all-ones code, a zero-length code,
    // two lengths above the limit that must clamp to 32, an 8-bit code whose word
    // carries junk above its length, a 7-bit code and a 3-bit all-zero code. One load
    // carries an end-of-stream flag that must be ignored.
    queue_load(8'd0,   6'd1,  32'h0000_0001, 1'b0);
    queue_load(8'd255, 6'd32, 32'hFFFF_FFFF, 1'b0);
    queue_load(8'd1,   6'd0,  32'hDEAD_BEEF, 1'b1);
    queue_load(8'd2,   6'd63, 32'hA5A5_A5A5, 1'b0);
    queue_load(8'd3,   6'd33, 32'h1234_5678, 1'b0);
    queue_load(8'd4,   6'd8,  32'hFFFF_FF00, 1'b0);
    queue_load(8'd5,   6'd7,  32'h0000_0055, 1'b0);
    queue_load(8'd6,   6'd3,  32'h0000_0000, 1'b0);
    // A 32-bit code on an empty accumulator gives four whole bytes.
    queue_encode(8'd255, 1'b0);
    // One bit, then 32 more closing the stream: four full bytes plus a padded one,
    // the most one transaction can cause.
    queue_encode(8'd0,   1'b0);
    queue_encode(8'd255, 1'b1);
    // End of stream with nothing buffered and nothing added: no byte, no mark.
    queue_encode(8'd1,   1'b1);
    // End of stream that lands exactly on a byte boundary: the mark rides the full byte.
    queue_encode(8'd4,   1'b1);
    // Clamped lengths and a zero-length code in the middle of a stream.
    queue_encode(8'd2,   1'b0);
    queue_encode(8'd1,   1'b0);
    queue_encode(8'd3,   1'b0);
    queue_encode(8'd6,   1'b0);
    queue_encode(8'd5,   1'b1);
    // Reload an entry and encode it right behind the load.
    queue_load(8'd0,   6'd5,  32'h0000_0013, 1'b0);
    queue_encode(8'd0,   1'b1);
    queue_random_items(PHASE_ITEMS);
    // The sender pauses here until every byte of the phase is back.
    wait_drained();

    // Second phase: the idling roles swap.
    tx_idle_pct = 80;
    rx_idle_pct = 31;
    queue_random_items(PHASE_ITEMS);
    wait_drained();

    // Third phase: no idling on either side, with one long receiver hold-off while
    // the sender keeps offering symbols.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random_items(PHASE_ITEMS);
    @(posedge clk_i);
    hold_trig <= 1'b1;
    @(posedge clk_i);
    hold_trig <= 1'b0;
    wait_drained();

    // Give late or extra bytes a chance to show up before the verdict.
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/hcbp_pkg.sv
rtl/core/hcbp_if.sv
rtl/core/hcbp_ram.sv
rtl/core/hcbp_emit.sv
rtl/core/huffman_code_bit_packer.sv
sim/huffman_code_bit_packer_tb.sv
